FILE: design/ppac_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppac_pkg
// Shared widths, codes, reset values and axis job types for the PI position
// and altitude controller.
// ----------------------------------------------------------------------------
package ppac_pkg;

    localparam int ERR_W      = 32;
    localparam int GAIN_W     = 32;
    localparam int LIM_W      = 31;
    localparam int DB_W       = 17;
    localparam int DT_W       = 24;
    localparam int INTEG_W    = 32;
    localparam int CMD_W      = 32;
    localparam int REQ_W      = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [REQ_W-1:0] REQ_HORIZ = 2'd0;
    localparam logic [REQ_W-1:0] REQ_VERT  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P_HORIZ = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I_HORIZ = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P_VERT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I_VERT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_HORIZ  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_VERT   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND     = 3'd6;

    localparam logic [GAIN_W-1:0] RST_GAIN_P_HORIZ = 32'd107374;
    localparam logic [GAIN_W-1:0] RST_GAIN_I_HORIZ = 32'd91268055;
    localparam logic [GAIN_W-1:0] RST_GAIN_P_VERT  = 32'd375809638;
    localparam logic [GAIN_W-1:0] RST_GAIN_I_VERT  = 32'd53687091;
    localparam logic [LIM_W-1:0]  RST_LIMIT_HORIZ  = 31'd131072;
    localparam logic [LIM_W-1:0]  RST_LIMIT_VERT   = 31'd65536;
    localparam logic [DB_W-1:0]   RST_DEADBAND     = 17'd328;

    typedef struct packed {
        logic signed [ERR_W-1:0]   err;
        logic [GAIN_W-1:0]         kp;
        logic [GAIN_W-1:0]         ki;
        logic [LIM_W-1:0]          lim;
        logic [DT_W-1:0]           dt;
        logic signed [INTEG_W-1:0] integ;
    } ppac_axis_job_t;

    typedef struct packed {
        logic signed [INTEG_W-1:0] integ;
        logic signed [CMD_W-1:0]   cmd;
    } ppac_axis_res_t;

endpackage

FILE: design/pi_position_altitude_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pi_position_altitude_controller
// PI position and altitude controller in Q16.16 with deadband, clamping and
// back-calculation anti-windup.
// ----------------------------------------------------------------------------
// One request is taken at a time. A vertical or horizontal step holds the
// request side while it runs; a horizontal step runs its two axes one after
// the other through a single axis unit with bit-serial gain and time-step
// multiplies. The result becomes valid in the same cycle as the next request
// can be taken. Clear and unknown requests skip the axis unit.
// A finished result sits in the output register until its transfer, while the
// next request is already taken in; a second result waits for that transfer.
module pi_position_altitude_controller #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   req_valid,
    output logic                                   req_ready,
    input  logic [ppac_pkg::REQ_W-1:0]             req_type,
    input  logic signed [ppac_pkg::ERR_W-1:0]      err_a,
    input  logic signed [ppac_pkg::ERR_W-1:0]      err_b,
    input  logic [ppac_pkg::DT_W-1:0]              dt_step,
    output logic                                   rsp_valid,
    input  logic                                   rsp_ready,
    output logic signed [ppac_pkg::CMD_W-1:0]      cmd_a,
    output logic signed [ppac_pkg::CMD_W-1:0]      cmd_b,
    input  logic                                   cfg_we,
    input  logic [ppac_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [ppac_pkg::CFG_DATA_W-1:0]        cfg_data
);
    import ppac_pkg::*;

    localparam logic [2:0] T_IDLE  = 3'd0;
    localparam logic [2:0] T_NORTH = 3'd1;
    localparam logic [2:0] T_EAST  = 3'd2;
    localparam logic [2:0] T_VERT  = 3'd3;
    localparam logic [2:0] T_DONE  = 3'd4;

    logic [GAIN_W-1:0]         kp_h_reg, ki_h_reg, kp_v_reg, ki_v_reg;
    logic [LIM_W-1:0]          lim_h_reg, lim_v_reg;
    logic [DB_W-1:0]           db_reg;

    logic [2:0]                state_reg, state_next;
    logic                      start_reg, start_next;
    logic signed [ERR_W-1:0]   ea_reg, ea_next, eb_reg, eb_next;
    logic [DT_W-1:0]           dt_reg, dt_next;
    logic signed [INTEG_W-1:0] int_n_reg, int_n_next;
    logic signed [INTEG_W-1:0] int_e_reg, int_e_next;
    logic signed [INTEG_W-1:0] int_v_reg, int_v_next;
    logic signed [CMD_W-1:0]   res_a_reg, res_a_next, res_b_reg, res_b_next;
    logic signed [CMD_W-1:0]   out_a_reg, out_a_next, out_b_reg, out_b_next;
    logic                      out_valid_reg, out_valid_next;

    ppac_axis_job_t            job;
    ppac_axis_res_t            axis_res;
    logic                      axis_done;
    logic signed [ERR_W-1:0]   e_raw;
    logic signed [ERR_W:0]     e_wide, db_wide;
    logic signed [ERR_W-1:0]   e_db;
    logic                      req_xfer;

    assign req_xfer = req_valid && req_ready;
    assign req_ready = (state_reg == T_IDLE);

    // deadband on horizontal errors only
    always_comb
    begin
        e_raw   = (state_reg == T_EAST) ? eb_reg : ea_reg;
        e_wide  = (ERR_W+1)'(e_raw);
        db_wide = $signed({{(ERR_W+1-DB_W){1'b0}}, db_reg});
        if (state_reg == T_VERT)
        begin
            e_db = e_raw;
        end
        else if (e_wide > db_wide)
        begin
            e_db = ERR_W'(e_wide - db_wide);
        end
        else if (e_wide < -db_wide)
        begin
            e_db = ERR_W'(e_wide + db_wide);
        end
        else
        begin
            e_db = '0;
        end
        job.err = e_db;
        job.dt  = dt_reg;
        if (state_reg == T_VERT)
        begin
            job.kp    = kp_v_reg;
            job.ki    = ki_v_reg;
            job.lim   = lim_v_reg;
            job.integ = int_v_reg;
        end
        else
        begin
            job.kp    = kp_h_reg;
            job.ki    = ki_h_reg;
            job.lim   = lim_h_reg;
            job.integ = (state_reg == T_EAST) ? int_e_reg : int_n_reg;
        end
    end

    ppac_axis #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_axis (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_reg),
        .job   (job),
        .done  (axis_done),
        .res   (axis_res)
    );

    always_comb
    begin
        state_next     = state_reg;
        start_next     = 1'b0;
        ea_next        = ea_reg;
        eb_next        = eb_reg;
        dt_next        = dt_reg;
        int_n_next     = int_n_reg;
        int_e_next     = int_e_reg;
        int_v_next     = int_v_reg;
        res_a_next     = res_a_reg;
        res_b_next     = res_b_reg;
        out_a_next     = out_a_reg;
        out_b_next     = out_b_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            T_IDLE:
            begin
                if (req_xfer)
                begin
                    ea_next    = err_a;
                    eb_next    = err_b;
                    dt_next    = dt_step;
                    res_a_next = '0;
                    res_b_next = '0;
                    unique case (req_type)
                        REQ_HORIZ:
                        begin
                            start_next = 1'b1;
                            state_next = T_NORTH;
                        end
                        REQ_VERT:
                        begin
                            start_next = 1'b1;
                            state_next = T_VERT;
                        end
                        REQ_CLEAR:
                        begin
                            int_n_next = '0;
                            int_e_next = '0;
                            int_v_next = '0;
                            state_next = T_DONE;
                        end
                        default:
                        begin
                            state_next = T_DONE;
                        end
                    endcase
                end
            end
            T_NORTH:
            begin
                if (axis_done)
                begin
                    int_n_next = axis_res.integ;
                    res_a_next = axis_res.cmd;
                    start_next = 1'b1;
                    state_next = T_EAST;
                end
            end
            T_EAST:
            begin
                if (axis_done)
                begin
                    int_e_next = axis_res.integ;
                    res_b_next = axis_res.cmd;
                    state_next = T_DONE;
                end
            end
            T_VERT:
            begin
                if (axis_done)
                begin
                    int_v_next = axis_res.integ;
                    res_a_next = axis_res.cmd;
                    state_next = T_DONE;
                end
            end
            T_DONE:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    out_a_next     = res_a_reg;
                    out_b_next     = res_b_reg;
                    out_valid_next = 1'b1;
                    state_next     = T_IDLE;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            int_n_reg     <= '0;
            int_e_reg     <= '0;
            int_v_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
            int_n_reg     <= int_n_next;
            int_e_reg     <= int_e_next;
            int_v_reg     <= int_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ea_reg    <= ea_next;
        eb_reg    <= eb_next;
        dt_reg    <= dt_next;
        res_a_reg <= res_a_next;
        res_b_reg <= res_b_next;
        out_a_reg <= out_a_next;
        out_b_reg <= out_b_next;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_h_reg  <= RST_GAIN_P_HORIZ;
            ki_h_reg  <= RST_GAIN_I_HORIZ;
            kp_v_reg  <= RST_GAIN_P_VERT;
            ki_v_reg  <= RST_GAIN_I_VERT;
            lim_h_reg <= RST_LIMIT_HORIZ;
            lim_v_reg <= RST_LIMIT_VERT;
            db_reg    <= RST_DEADBAND;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_GAIN_P_HORIZ: kp_h_reg  <= cfg_data;
                CFG_GAIN_I_HORIZ: ki_h_reg  <= cfg_data;
                CFG_GAIN_P_VERT:  kp_v_reg  <= cfg_data;
                CFG_GAIN_I_VERT:  ki_v_reg  <= cfg_data;
                CFG_LIMIT_HORIZ:  lim_h_reg <= cfg_data[LIM_W-1:0];
                CFG_LIMIT_VERT:   lim_v_reg <= cfg_data[LIM_W-1:0];
                CFG_DEADBAND:     db_reg    <= cfg_data[DB_W-1:0];
                default:          ;
            endcase
        end
    end

    assign rsp_valid = out_valid_reg;
    assign cmd_a     = out_a_reg;
    assign cmd_b     = out_b_reg;

    a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        (req_xfer && req_type == REQ_CLEAR) |=>
            (int_n_reg == '0 && int_e_reg == '0 && int_v_reg == '0))
        else $error("clear transfer left an integrator set");

    a_done_in_axis_state: assert property (@(posedge clk) disable iff (!rst_n)
        axis_done |-> (state_reg == T_NORTH || state_reg == T_EAST || state_reg == T_VERT))
        else $error("axis result outside an axis step");

    a_start_in_axis_state: assert property (@(posedge clk) disable iff (!rst_n)
        start_reg |-> (state_reg == T_NORTH || state_reg == T_EAST || state_reg == T_VERT))
        else $error("axis launched outside an axis step");

    a_east_after_north: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == T_NORTH && axis_done) |=> (state_reg == T_EAST && start_reg))
        else $error("east axis not launched after north");

endmodule

FILE: design/ppac_axis.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppac_axis
// One PI axis with back-calculation anti-windup, gains and time step applied
// by bit-serial shift-and-add multipliers.
// ----------------------------------------------------------------------------
module ppac_axis #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  ppac_pkg::ppac_axis_job_t job,
    output logic                     done,
    output ppac_pkg::ppac_axis_res_t res
);
    import ppac_pkg::*;

    localparam int PROD_W = ERR_W + GAIN_W + 1;
    localparam int SW     = (DATA_WIDTH > 36 ? DATA_WIDTH : 36) + 4;
    localparam int TW     = DATA_WIDTH + DT_W + 1;
    localparam int CNT_W  = $clog2(GAIN_W > DT_W ? GAIN_W : DT_W);
    localparam int FRAC_G = GAIN_W - 2;

    localparam logic signed [SW-1:0] DW_MAX = SW'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] DW_MIN = -DW_MAX - SW'(1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL   = 4'd1;
    localparam logic [3:0] S_PSAT  = 4'd2;
    localparam logic [3:0] S_SUM   = 4'd3;
    localparam logic [3:0] S_CLAMP = 4'd4;
    localparam logic [3:0] S_TERM  = 4'd5;
    localparam logic [3:0] S_DTMUL = 4'd6;
    localparam logic [3:0] S_UPD   = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    function automatic logic signed [SW-1:0] clamp_lim(
        input logic signed [SW-1:0] v,
        input logic signed [SW-1:0] l
    );
        logic signed [SW-1:0] r;
        if (v > l)
        begin
            r = l;
        end
        else if (v < -l)
        begin
            r = -l;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    logic [3:0]                state_reg, state_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic [GAIN_W-1:0]         kp_sh_reg, kp_sh_next;
    logic [GAIN_W-1:0]         ki_sh_reg, ki_sh_next;
    logic [DT_W-1:0]           dt_sh_reg, dt_sh_next;
    logic signed [ERR_W-1:0]   e_reg, e_next;
    logic [LIM_W-1:0]          lim_reg, lim_next;
    logic signed [INTEG_W-1:0] integ_reg, integ_next;
    logic signed [PROD_W-1:0]  acc_p_reg, acc_p_next;
    logic signed [PROD_W-1:0]  acc_i_reg, acc_i_next;
    logic signed [SW-1:0]      p_reg, p_next;
    logic signed [SW-1:0]      eterm_reg, eterm_next;
    logic signed [SW-1:0]      unsat_reg, unsat_next;
    logic signed [SW-1:0]      diff_reg, diff_next;
    logic signed [SW-1:0]      term_reg, term_next;
    logic signed [TW-1:0]      acc_t_reg, acc_t_next;
    logic signed [INTEG_W-1:0] integ_new_reg, integ_new_next;
    logic signed [CMD_W-1:0]   cmd_reg, cmd_next;
    logic                      done_reg, done_next;

    logic signed [PROD_W-1:0]  e_ext;
    logic signed [PROD_W-1:0]  p_shift, i_shift;
    logic signed [SW-1:0]      p_full;
    logic signed [SW-1:0]      lim_ext, integ_ext, integ_new_ext;
    logic signed [SW-1:0]      sat_val, t_sum, delta_ext;
    logic signed [TW-1:0]      term_ext, t_shift;
    logic                      e_pos, e_neg, freeze;

    always_comb
    begin
        e_ext         = PROD_W'(e_reg);
        p_shift       = acc_p_reg >>> FRAC_G;
        i_shift       = acc_i_reg >>> FRAC_G;
        p_full        = $signed(p_shift[SW-1:0]);
        lim_ext       = $signed({{(SW-LIM_W){1'b0}}, lim_reg});
        integ_ext     = SW'(integ_reg);
        integ_new_ext = SW'(integ_new_reg);
        sat_val       = clamp_lim(unsat_reg, lim_ext);
        e_pos         = !e_reg[ERR_W-1] && (|e_reg);
        e_neg         = e_reg[ERR_W-1];
        freeze        = ((unsat_reg > lim_ext) && e_pos) || ((unsat_reg < -lim_ext) && e_neg);
        t_sum         = eterm_reg + (diff_reg <<< 1);
        term_ext      = TW'($signed(term_reg[DATA_WIDTH-1:0]));
        t_shift       = acc_t_reg >>> DT_W;
        delta_ext     = SW'($signed(t_shift[DATA_WIDTH:0]));
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        kp_sh_next     = kp_sh_reg;
        ki_sh_next     = ki_sh_reg;
        dt_sh_next     = dt_sh_reg;
        e_next         = e_reg;
        lim_next       = lim_reg;
        integ_next     = integ_reg;
        acc_p_next     = acc_p_reg;
        acc_i_next     = acc_i_reg;
        p_next         = p_reg;
        eterm_next     = eterm_reg;
        unsat_next     = unsat_reg;
        diff_next      = diff_reg;
        term_next      = term_reg;
        acc_t_next     = acc_t_reg;
        integ_new_next = integ_new_reg;
        cmd_next       = cmd_reg;
        done_next      = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    kp_sh_next = job.kp;
                    ki_sh_next = job.ki;
                    dt_sh_next = job.dt;
                    e_next     = job.err;
                    lim_next   = job.lim;
                    integ_next = job.integ;
                    acc_p_next = '0;
                    acc_i_next = '0;
                    cnt_next   = CNT_W'(GAIN_W - 1);
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                acc_p_next = (acc_p_reg <<< 1) + (kp_sh_reg[GAIN_W-1] ? e_ext : '0);
                acc_i_next = (acc_i_reg <<< 1) + (ki_sh_reg[GAIN_W-1] ? e_ext : '0);
                kp_sh_next = kp_sh_reg << 1;
                ki_sh_next = ki_sh_reg << 1;
                cnt_next   = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    state_next = S_PSAT;
                end
            end
            S_PSAT:
            begin
                if (p_full > DW_MAX)
                begin
                    p_next = DW_MAX;
                end
                else if (p_full < DW_MIN)
                begin
                    p_next = DW_MIN;
                end
                else
                begin
                    p_next = p_full;
                end
                eterm_next = $signed(i_shift[SW-1:0]);
                state_next = S_SUM;
            end
            S_SUM:
            begin
                unsat_next = p_reg + integ_ext;
                state_next = S_CLAMP;
            end
            S_CLAMP:
            begin
                diff_next = sat_val - unsat_reg;
                if (freeze)
                begin
                    eterm_next = '0;
                end
                state_next = S_TERM;
            end
            S_TERM:
            begin
                if (t_sum > DW_MAX)
                begin
                    term_next = DW_MAX;
                end
                else if (t_sum < DW_MIN)
                begin
                    term_next = DW_MIN;
                end
                else
                begin
                    term_next = t_sum;
                end
                acc_t_next = '0;
                cnt_next   = CNT_W'(DT_W - 1);
                state_next = S_DTMUL;
            end
            S_DTMUL:
            begin
                acc_t_next = (acc_t_reg <<< 1) + (dt_sh_reg[DT_W-1] ? term_ext : '0);
                dt_sh_next = dt_sh_reg << 1;
                cnt_next   = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                integ_new_next = INTEG_W'(clamp_lim(integ_ext + delta_ext, lim_ext));
                state_next     = S_OUT;
            end
            S_OUT:
            begin
                cmd_next   = CMD_W'(clamp_lim(p_reg + integ_new_ext, lim_ext));
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kp_sh_reg     <= kp_sh_next;
        ki_sh_reg     <= ki_sh_next;
        dt_sh_reg     <= dt_sh_next;
        e_reg         <= e_next;
        lim_reg       <= lim_next;
        integ_reg     <= integ_next;
        acc_p_reg     <= acc_p_next;
        acc_i_reg     <= acc_i_next;
        p_reg         <= p_next;
        eterm_reg     <= eterm_next;
        unsat_reg     <= unsat_next;
        diff_reg      <= diff_next;
        term_reg      <= term_next;
        acc_t_reg     <= acc_t_next;
        integ_new_reg <= integ_new_next;
        cmd_reg       <= cmd_next;
    end

    assign done      = done_reg;
    assign res.integ = integ_new_reg;
    assign res.cmd   = cmd_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> (state_reg == S_IDLE))
        else $error("axis start while busy");

    a_done_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(state_reg) == S_OUT))
        else $error("axis done without output step");

    a_mul_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL && cnt_reg != '0) |=> (state_reg == S_MUL))
        else $error("gain multiply cut short");

endmodule
